// File: hw/rtl/cpt_pkg.sv
`default_nettype none

package cpt_pkg;

  // Input actions
  typedef enum logic [1:0] {
    ACT_CONTACT = 2'd0,
    ACT_AGE     = 2'd1,
    ACT_SWEEP   = 2'd2,
    ACT_REMOVE  = 2'd3
  } action_e;

  // Reported event codes
  typedef enum logic [1:0] {
    EV_ENTER   = 2'd0,
    EV_STAY    = 2'd1,
    EV_EXIT    = 2'd2,
    EV_DROPPED = 2'd3
  } event_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXIT_TIMEOUT = 1'd0,
    CFG_SELF_TRIGGER = 1'd1
  } cfg_idx_e;

  localparam int unsigned  CfgDataW        = 32;
  localparam logic [31:0]  ExitTimeoutRst  = 32'd100000;

  // Sweep reports at most this many exits per transaction
  localparam int unsigned MaxOut   = 16;
  localparam int unsigned ExitCntW = 5;

  // One table slot as held in the slot memory
  typedef struct packed {
    logic [15:0]        partner;
    logic [31:0]        age;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               trig;
  } entry_t;

  // Per-slot evaluation flags
  typedef struct packed {
    logic hit;
    logic expired;
    logic is_free;
  } eval_t;

  // One result transaction
  typedef struct packed {
    event_e             ev;
    logic               trig;
    logic [15:0]        id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/cpt_slot_eval.sv
`default_nettype none

// Evaluates one slot read from the table: match, expiry, free, and the
// updated entry for contact hits and aging.
module cpt_slot_eval (
  input  wire cpt_pkg::entry_t      entry_i,
  input  wire                       valid_i,
  input  wire cpt_pkg::action_e     action_i,
  input  wire [15:0]                partner_id_i,
  input  wire [15:0]                delta_time_i,
  input  wire signed [31:0]         point_x_i,
  input  wire signed [31:0]         point_y_i,
  input  wire signed [31:0]         point_z_i,
  input  wire [31:0]                exit_timeout_i,
  output cpt_pkg::eval_t            eval_o,
  output cpt_pkg::entry_t           entry_o
);

  logic [32:0] age_sum;
  logic [31:0] age_sat;

  // Saturating age update
  assign age_sum = {1'b0, entry_i.age} + {17'b0, delta_time_i};
  assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];

  assign eval_o.hit     = valid_i && (entry_i.partner == partner_id_i);
  assign eval_o.expired = valid_i && (entry_i.age > exit_timeout_i);
  assign eval_o.is_free = !valid_i;

  // Contact hit keeps partner and trigger flag, refreshes age and point
  always_comb begin
    entry_o = entry_i;
    if (action_i == cpt_pkg::ACT_CONTACT) begin
      entry_o.age = 32'd0;
      entry_o.px  = point_x_i;
      entry_o.py  = point_y_i;
      entry_o.pz  = point_z_i;
    end else begin
      entry_o.age = age_sat;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/contact_presence_tracker.sv
`default_nettype none

// Contact presence tracker: a table of ENTRIES slots naming the partners
// touching this body. Input transactions (in_valid_i / in_stall_o) carry an
// action: contact, age, sweep or remove. Result transactions
// (out_valid_o / out_stall_i) carry enter, stay, exit or dropped events;
// last_o marks the final result of an input. Age, a sweep with nothing
// expired and a remove of an absent partner give no result.
// Each input walks the slot memory, one slot per cycle through its single
// read port unless a sweep pauses. A new input is accepted only once the
// previous input is done and its result, if any, is in the output register;
// a contact or remove hit ends the walk early. A sweep holds one exit back so
// it can mark the last one, and pauses its walk when the output register is
// still full. The output register lets the next input be accepted while a
// result waits. Reset clears every slot's valid flip-flop at once and
// restores the configuration; slot memory contents need no clearing. While
// out_stall_i is high, the result on the outputs holds and a sweep can stall.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i.
module contact_presence_tracker #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration
  input  wire                              cfg_we_i,
  input  wire [cpt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [cpt_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // input channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire [1:0]                        action_i,
  input  wire [15:0]                       partner_id_i,
  input  wire                              partner_trigger_i,
  input  wire signed [31:0]                point_x_i,
  input  wire signed [31:0]                point_y_i,
  input  wire signed [31:0]                point_z_i,
  input  wire [15:0]                       delta_time_i,
  // output channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [1:0]                       event_res_o,
  output logic                             is_trigger_o,
  output logic [15:0]                      other_id_o,
  output logic signed [31:0]               out_x_o,
  output logic signed [31:0]               out_y_o,
  output logic signed [31:0]               out_z_o,
  output logic                             last_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned ExitCntWL = cpt_pkg::ExitCntW;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [31:0] exit_timeout_q;
  logic        self_trig_q;

  // latched command
  cpt_pkg::action_e   cmd_action_q;
  logic [15:0]        cmd_id_q;
  logic               cmd_trig_q;
  logic signed [31:0] cmd_x_q, cmd_y_q, cmd_z_q;
  logic [15:0]        cmd_dt_q;

  // walk control
  logic [CntW-1:0]     rd_cnt_q, rd_cnt_d;
  logic                ev_valid_q, ev_valid_d;
  logic [IdxW-1:0]     ev_idx_q, ev_idx_d;
  logic                free_found_q, free_found_d;
  logic [IdxW-1:0]     free_idx_q, free_idx_d;
  logic [ExitCntWL-1:0] exit_cnt_q, exit_cnt_d;

  logic [ENTRIES-1:0] valid_q, valid_d;

  // slot memory
  cpt_pkg::entry_t mem_q [ENTRIES];
  cpt_pkg::entry_t rdata_q;
  logic            mem_re;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  cpt_pkg::entry_t mem_wdata;

  // result holding and output register
  cpt_pkg::res_t pend_q, pend_d;
  logic          pend_valid_q, pend_valid_d;
  cpt_pkg::res_t out_q, out_d;
  logic          out_last_q, out_last_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  cpt_pkg::eval_t  ev;
  cpt_pkg::entry_t upd;
  logic            rd_more;
  logic            proceed;
  logic            in_accept;
  cpt_pkg::res_t   exit_res;
  cpt_pkg::res_t   cmd_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_more    = (rd_cnt_q != CntW'(ENTRIES));

  cpt_slot_eval u_eval (
    .entry_i        (rdata_q),
    .valid_i        (valid_q[ev_idx_q]),
    .action_i       (cmd_action_q),
    .partner_id_i   (cmd_id_q),
    .delta_time_i   (cmd_dt_q),
    .point_x_i      (cmd_x_q),
    .point_y_i      (cmd_y_q),
    .point_z_i      (cmd_z_q),
    .exit_timeout_i (exit_timeout_q),
    .eval_o         (ev),
    .entry_o        (upd)
  );

  // Candidate results
  always_comb begin
    exit_res.ev   = cpt_pkg::EV_EXIT;
    exit_res.trig = rdata_q.trig;
    exit_res.id   = rdata_q.partner;
    exit_res.x    = rdata_q.px;
    exit_res.y    = rdata_q.py;
    exit_res.z    = rdata_q.pz;
    cmd_res.ev    = cpt_pkg::EV_STAY;
    cmd_res.trig  = cmd_trig_q;
    cmd_res.id    = cmd_id_q;
    cmd_res.x     = cmd_x_q;
    cmd_res.y     = cmd_y_q;
    cmd_res.z     = cmd_z_q;
  end

  // A sweep exit needs room to push the held exit forward
  assign proceed = !(ev_valid_q && (cmd_action_q == cpt_pkg::ACT_SWEEP) && ev.expired &&
                     pend_valid_q && !out_free);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    rd_cnt_d     = rd_cnt_q;
    ev_valid_d   = ev_valid_q;
    ev_idx_d     = ev_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    exit_cnt_d   = exit_cnt_q;
    valid_d      = valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = ev_idx_q;
    mem_wdata    = upd;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          rd_cnt_d     = '0;
          ev_valid_d   = 1'b0;
          free_found_d = 1'b0;
          exit_cnt_d   = '0;
          state_d      = ST_WALK;
        end
      end

      ST_WALK: begin
        if (proceed) begin
          // issue the next slot read
          if (rd_more) begin
            mem_re     = 1'b1;
            rd_cnt_d   = rd_cnt_q + CntW'(1);
            ev_valid_d = 1'b1;
            ev_idx_d   = rd_cnt_q[IdxW-1:0];
          end else begin
            ev_valid_d = 1'b0;
          end
        end

        if (!ev_valid_q && !rd_more) begin
          state_d = ST_FINISH;
        end else if (ev_valid_q && proceed) begin
          unique case (cmd_action_q)
            cpt_pkg::ACT_CONTACT: begin
              if (ev.hit) begin
                mem_we       = 1'b1;
                pend_d       = cmd_res;
                pend_valid_d = 1'b1;
                state_d      = ST_FINISH;
              end else if (ev.is_free && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = ev_idx_q;
              end
            end
            cpt_pkg::ACT_AGE: begin
              mem_we = !ev.is_free;
            end
            cpt_pkg::ACT_SWEEP: begin
              if (ev.expired) begin
                valid_d[ev_idx_q] = 1'b0;
                if (pend_valid_q) begin
                  out_d       = pend_q;
                  out_last_d  = 1'b0;
                  out_valid_d = 1'b1;
                end
                pend_d       = exit_res;
                pend_valid_d = 1'b1;
                exit_cnt_d   = exit_cnt_q + ExitCntWL'(1);
                if (exit_cnt_q == ExitCntWL'(cpt_pkg::MaxOut - 1)) begin
                  state_d = ST_FINISH;
                end
              end
            end
            cpt_pkg::ACT_REMOVE: begin
              if (ev.hit) begin
                valid_d[ev_idx_q] = 1'b0;
                pend_d            = exit_res;
                pend_valid_d      = 1'b1;
                state_d           = ST_FINISH;
              end
            end
            default: ;
          endcase
        end
      end

      ST_FINISH: begin
        // contact miss: enter into the lowest free slot or drop
        if (cmd_action_q == cpt_pkg::ACT_CONTACT && !pend_valid_q) begin
          pend_d       = cmd_res;
          pend_valid_d = 1'b1;
          if (free_found_q) begin
            pend_d.ev             = cpt_pkg::EV_ENTER;
            valid_d[free_idx_q]   = 1'b1;
            mem_we                = 1'b1;
            mem_waddr             = free_idx_q;
            mem_wdata.partner     = cmd_id_q;
            mem_wdata.age         = 32'd0;
            mem_wdata.px          = cmd_x_q;
            mem_wdata.py          = cmd_y_q;
            mem_wdata.pz          = cmd_z_q;
            mem_wdata.trig        = cmd_trig_q;
          end else begin
            pend_d.ev = cpt_pkg::EV_DROPPED;
          end
        end
        state_d = ST_FLUSH;
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d        = pend_q;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_cnt_q     <= '0;
      ev_valid_q   <= 1'b0;
      free_found_q <= 1'b0;
      exit_cnt_q   <= '0;
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_cnt_q     <= rd_cnt_d;
      ev_valid_q   <= ev_valid_d;
      free_found_q <= free_found_d;
      exit_cnt_q   <= exit_cnt_d;
      valid_q      <= valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exit_timeout_q <= cpt_pkg::ExitTimeoutRst;
      self_trig_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpt_pkg::CFG_EXIT_TIMEOUT: exit_timeout_q <= cfg_wdata_i[31:0];
        cpt_pkg::CFG_SELF_TRIGGER: self_trig_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_action_q <= cpt_pkg::action_e'(action_i);
      cmd_id_q     <= partner_id_i;
      cmd_trig_q   <= partner_trigger_i | self_trig_q;
      cmd_x_q      <= point_x_i;
      cmd_y_q      <= point_y_i;
      cmd_z_q      <= point_z_i;
      cmd_dt_q     <= delta_time_i;
    end
    ev_idx_q   <= ev_idx_d;
    free_idx_q <= free_idx_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_cnt_q[IdxW-1:0]];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = out_q.ev;
  assign is_trigger_o = out_q.trig;
  assign other_id_o   = out_q.id;
  assign out_x_o      = out_q.x;
  assign out_y_o      = out_q.y;
  assign out_z_o      = out_q.z;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

// File: bench/tb.sv
module tb;

  localparam int Slots       = 16;
  localparam int DrainCycles = 3 * Slots;
  localparam int DrainBound  = 20000;
  localparam int CycleLimit  = 500_000;
  localparam int PoolSize    = 20;
  localparam int PhaseItems  = 85;
  localparam int Phases      = 5;

  // One input transaction as driven onto the ports
  typedef struct packed {
    cpt_pkg::action_e   act;
    logic [15:0]        id;
    logic               ptrig;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        dt;
  } contact_item_t;

  // One reported event, field order matches the output ports
  typedef struct packed {
    cpt_pkg::event_e    ev;
    logic               trig;
    logic [15:0]        id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } presence_event_t;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_COIN,
    STALL_HEAVY
  } stall_mode_e;

  // Contact table mirror plus the queue of events it predicts
  class contact_ledger;
    bit                 used   [Slots];
    logic [15:0]        pid    [Slots];
    logic [31:0]        age    [Slots];
    logic signed [31:0] px     [Slots];
    logic signed [31:0] py     [Slots];
    logic signed [31:0] pz     [Slots];
    bit                 strig  [Slots];
    logic [31:0]        timeout;
    bit                 self_trig;
    presence_event_t    events_due[$];
    int                 mismatches;

    function new();
      timeout    = cpt_pkg::ExitTimeoutRst;
      self_trig  = 1'b0;
      mismatches = 0;
      foreach (used[s]) used[s] = 1'b0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void set_reg(cpt_pkg::cfg_idx_e idx, logic [31:0] v);
      case (idx)
        cpt_pkg::CFG_EXIT_TIMEOUT: timeout = v;
        cpt_pkg::CFG_SELF_TRIGGER: self_trig = v[0];
        default: ;
      endcase
    endfunction

    function void push_event(cpt_pkg::event_e ev, bit trig, logic [15:0] id,
                             logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, bit last);
      presence_event_t e;
      e = '{ev: ev, trig: trig, id: id, x: x, y: y, z: z, last: last};
      events_due = {events_due, e};
    endfunction

    // exit event from the stored entry, then free the slot
    function void retire(int s);
      push_event(cpt_pkg::EV_EXIT, strig[s], pid[s], px[s], py[s], pz[s], 1'b0);
      used[s] = 1'b0;
    endfunction

    function void mark_last();
      presence_event_t e;
      e = events_due.pop_back();
      e.last = 1'b1;
      events_due = {events_due, e};
    endfunction

    // Accepted input: update the table and queue the events it causes
    function void accept_action(contact_item_t it);
      bit          trig;
      int          free_s;
      int          n;
      logic [32:0] sum;
      trig   = it.ptrig | self_trig;
      free_s = -1;
      n      = 0;
      case (it.act)
        cpt_pkg::ACT_CONTACT: begin
          for (int s = 0; s < Slots; s++) begin
            if (used[s] && pid[s] == it.id) begin
              // hit: stored trigger flag keeps its value from entry
              age[s] = '0;
              px[s]  = it.x;
              py[s]  = it.y;
              pz[s]  = it.z;
              push_event(cpt_pkg::EV_STAY, trig, it.id, it.x, it.y, it.z, 1'b1);
              return;
            end
            if (!used[s] && free_s < 0) free_s = s;
          end
          if (free_s >= 0) begin
            used[free_s]  = 1'b1;
            pid[free_s]   = it.id;
            age[free_s]   = '0;
            px[free_s]    = it.x;
            py[free_s]    = it.y;
            pz[free_s]    = it.z;
            strig[free_s] = trig;
            push_event(cpt_pkg::EV_ENTER, trig, it.id, it.x, it.y, it.z, 1'b1);
          end else begin
            push_event(cpt_pkg::EV_DROPPED, trig, it.id, it.x, it.y, it.z, 1'b1);
          end
        end
        cpt_pkg::ACT_AGE: begin
          // saturating add on every live entry
          for (int s = 0; s < Slots; s++) begin
            if (used[s]) begin
              sum    = {1'b0, age[s]} + {17'b0, it.dt};
              age[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
          end
        end
        cpt_pkg::ACT_SWEEP: begin
          for (int s = 0; s < Slots && n < cpt_pkg::MaxOut; s++) begin
            if (used[s] && age[s] > timeout) begin
              retire(s);
              n++;
            end
          end
          if (n > 0) mark_last();
        end
        cpt_pkg::ACT_REMOVE: begin
          for (int s = 0; s < Slots; s++) begin
            if (used[s] && pid[s] == it.id) begin
              retire(s);
              mark_last();
              return;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Accepted result against the oldest predicted event
    task match_event(presence_event_t got);
      presence_event_t want;
      if (events_due.size() == 0) begin
        report($sformatf("event %0d for id %h with nothing pending", got.ev, got.id));
        return;
      end
      want = events_due.pop_front();
      if (got.ev !== want.ev)
        report($sformatf("event_res got %0d want %0d (id %h)", got.ev, want.ev, want.id));
      if (got.trig !== want.trig)
        report($sformatf("is_trigger got %0d want %0d (id %h)", got.trig, want.trig, want.id));
      if (got.id !== want.id)
        report($sformatf("other_id got %h want %h", got.id, want.id));
      if (got.x !== want.x)
        report($sformatf("out_x got %h want %h (id %h)", got.x, want.x, want.id));
      if (got.y !== want.y)
        report($sformatf("out_y got %h want %h (id %h)", got.y, want.y, want.id));
      if (got.z !== want.z)
        report($sformatf("out_z got %h want %h (id %h)", got.z, want.z, want.id));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d (id %h)", got.last, want.last, want.id));
    endtask

    task report_leftover();
      presence_event_t e;
      while (events_due.size() != 0) begin
        e = events_due.pop_front();
        report($sformatf("event %0d for id %h never arrived", e.ev, e.id));
      end
    endtask
  endclass

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         cfg_we     = 1'b0;
  cpt_pkg::cfg_idx_e            cfg_idx    = cpt_pkg::CFG_EXIT_TIMEOUT;
  logic [cpt_pkg::CfgDataW-1:0] cfg_wdata  = '0;
  logic                         in_valid   = 1'b0;
  logic                         in_stall;
  contact_item_t                drive_item = '0;
  logic                         out_valid;
  logic                         out_stall  = 1'b0;
  logic [1:0]                   event_res;
  logic                         is_trigger;
  logic [15:0]                  other_id;
  logic signed [31:0]           out_x;
  logic signed [31:0]           out_y;
  logic signed [31:0]           out_z;
  logic                         last_out;
  presence_event_t              seen;

  contact_ledger                ledger;
  logic [15:0]                  id_pool [PoolSize];
  int unsigned                  burst_left = 0;
  stall_mode_e                  stall_mode = STALL_OFF;
  int unsigned                  stall_left = 0;
  int unsigned                  cycles     = 0;

  contact_presence_tracker #(
    .ENTRIES(Slots)
  ) u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (drive_item.act),
    .partner_id_i      (drive_item.id),
    .partner_trigger_i (drive_item.ptrig),
    .point_x_i         (drive_item.x),
    .point_y_i         (drive_item.y),
    .point_z_i         (drive_item.z),
    .delta_time_i      (drive_item.dt),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .event_res_o       (event_res),
    .is_trigger_o      (is_trigger),
    .other_id_o        (other_id),
    .out_x_o           (out_x),
    .out_y_o           (out_y),
    .out_z_o           (out_z),
    .last_o            (last_out)
  );

  assign seen = {event_res, is_trigger, other_id, out_x, out_y, out_z, last_out};

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // input transactions feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) ledger.accept_action(drive_item);
  end

  // result transactions are checked in order
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.match_event(seen);
  end

  // receiver back-pressure: modes of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(10, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_OFF:  out_stall <= 1'b0;
      STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
      default:    out_stall <= ($urandom_range(0, 5) != 0);
    endcase
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic contact_item_t make_action(cpt_pkg::action_e act, logic [15:0] id,
                                                logic ptrig,
                                                logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [15:0] dt);
    contact_item_t it;
    it = '{act: act, id: id, ptrig: ptrig, x: x, y: y, z: z, dt: dt};
    return it;
  endfunction

  // sender idles between bursts of random length
  function automatic int unsigned burst_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      return ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
    end
    burst_left--;
    return 0;
  endfunction

  // present one transaction, hold it until taken, then idle for gap cycles
  task automatic send(input contact_item_t it, input int unsigned gap);
    in_valid   <= 1'b1;
    drive_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every predicted event is out and the block has gone quiet
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (ledger.events_due.size() != 0 && waited < DrainBound) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  // both registers, back to back
  task automatic write_regs(input logic [31:0] tmo, input logic [31:0] st);
    cfg_we    <= 1'b1;
    cfg_idx   <= cpt_pkg::CFG_EXIT_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_idx   <= cpt_pkg::CFG_SELF_TRIGGER;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ledger.set_reg(cpt_pkg::CFG_EXIT_TIMEOUT, tmo);
    ledger.set_reg(cpt_pkg::CFG_SELF_TRIGGER, st);
  endtask

  initial begin
    contact_item_t it;
    int unsigned   pick;
    logic [31:0]   tmo;
    logic [31:0]   st;
    ledger = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_regs(32'd1000, 32'd0);

    // directed: extreme ids and points, hit, aging, sweep, absent remove
    send(make_action(cpt_pkg::ACT_CONTACT, 16'h0000, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h0, 16'($urandom)), burst_gap());
    send(make_action(cpt_pkg::ACT_CONTACT, 16'hFFFF, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF, 16'($urandom)), burst_gap());
    send(make_action(cpt_pkg::ACT_CONTACT, 16'h0000, 1'b1, $urandom, $urandom, $urandom,
                     16'h0), burst_gap());
    send(make_action(cpt_pkg::ACT_AGE, 16'($urandom), 1'b1, $urandom, $urandom, $urandom,
                     16'h0000), burst_gap());
    send(make_action(cpt_pkg::ACT_SWEEP, 16'($urandom), 1'b0, $urandom, $urandom, $urandom,
                     16'($urandom)), burst_gap());
    send(make_action(cpt_pkg::ACT_AGE, 16'($urandom), 1'b0, $urandom, $urandom, $urandom,
                     16'hFFFF), burst_gap());
    send(make_action(cpt_pkg::ACT_SWEEP, 16'($urandom), 1'b1, $urandom, $urandom, $urandom,
                     16'($urandom)), burst_gap());
    send(make_action(cpt_pkg::ACT_REMOVE, 16'h1234, 1'b0, $urandom, $urandom, $urandom,
                     16'($urandom)), burst_gap());
    // fill the table, then one contact too many
    for (int k = 0; k < Slots; k++) begin
      send(make_action(cpt_pkg::ACT_CONTACT, 16'h0100 + 16'(k), k[0], $urandom, $urandom,
                       $urandom, 16'($urandom)), burst_gap());
    end
    send(make_action(cpt_pkg::ACT_CONTACT, 16'h0200, 1'b1, $urandom, $urandom, $urandom,
                     16'($urandom)), burst_gap());
    // hit with a trigger partner on an entry stored as non-trigger, then remove it
    send(make_action(cpt_pkg::ACT_CONTACT, 16'h0104, 1'b1, $urandom, $urandom, $urandom,
                     16'($urandom)), burst_gap());
    send(make_action(cpt_pkg::ACT_REMOVE, 16'h0104, 1'b1, $urandom, $urandom, $urandom,
                     16'($urandom)), burst_gap());

    // random phases, each under its own register setting
    for (int p = 0; p < Phases; p++) begin
      settle();
      st = $urandom;
      case (p)
        0: begin tmo = 32'd0;                   st[0] = 1'b1; end
        1: begin tmo = 32'd700;                 st[0] = 1'b0; end
        2: begin tmo = cpt_pkg::ExitTimeoutRst; st[0] = 1'b1; end
        3: begin tmo = 32'hFFFF_FFFF;           st[0] = 1'b0; end
        default: tmo = $urandom_range(0, 300000);
      endcase
      write_regs(tmo, st);
      // more partners than slots so the table fills now and then
      foreach (id_pool[i]) id_pool[i] = 16'($urandom_range(0, 16'hFFFF));
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      repeat (PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      it.act = cpt_pkg::ACT_CONTACT;
        else if (pick < 63) it.act = cpt_pkg::ACT_AGE;
        else if (pick < 82) it.act = cpt_pkg::ACT_SWEEP;
        else                it.act = cpt_pkg::ACT_REMOVE;
        if ($urandom_range(0, 9) == 0) it.id = 16'($urandom_range(0, 16'hFFFF));
        else                           it.id = id_pool[$urandom_range(0, PoolSize - 1)];
        it.ptrig = ($urandom_range(0, 1) == 1);
        it.x     = $urandom;
        it.y     = $urandom;
        it.z     = $urandom;
        case ($urandom_range(0, 3))
          0:       it.dt = 16'h0000;
          1:       it.dt = 16'hFFFF;
          2:       it.dt = 16'($urandom_range(0, 255));
          default: it.dt = 16'($urandom_range(0, 16'hFFFF));
        endcase
        send(it, burst_gap());
      end
    end

    // empty the table: everything alive is older than a zero timeout
    settle();
    write_regs(32'd0, 32'd0);
    send(make_action(cpt_pkg::ACT_AGE, 16'($urandom), 1'b0, $urandom, $urandom, $urandom,
                     16'h0001), 0);
    send(make_action(cpt_pkg::ACT_SWEEP, 16'($urandom), 1'b0, $urandom, $urandom, $urandom,
                     16'($urandom)), 0);

    settle();
    ledger.report_leftover();
    if (ledger.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_slot_eval.sv
hw/rtl/contact_presence_tracker.sv
bench/tb.sv
